// ----- rtl/tme_pkg.sv -----
// ----------------------------------------------------------------------------
// tme_pkg
// Shared types and constants for the tape machine executor.
// ----------------------------------------------------------------------------
package tme_pkg;

    // Default sizes, used as parameter defaults on the top level
    localparam int TAPE_CELLS_DEF           = 4096;
    localparam int CELL_BITS_DEF            = 32;
    localparam int PROGRAM_ADDRESS_BITS_DEF = 16;

    // Depth of the decoupling queues (power of two, at least 2)
    localparam int QUEUE_DEPTH = 2;

    // Fixed field widths of the words
    localparam int CMD_W     = 3;
    localparam int OPERAND_W = 16;
    localparam int READ_W    = 9;
    localparam int NEXT_W    = 16;
    localparam int BYTE_W    = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 3'd0,
        CMD_SUB   = 3'd1,
        CMD_GET   = 3'd2,
        CMD_PUT   = 3'd3,
        CMD_RIGHT = 3'd4,
        CMD_LEFT  = 3'd5,
        CMD_OPEN  = 3'd6,
        CMD_CLOSE = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        CELL_KEEP,
        CELL_ADD,
        CELL_SUB,
        CELL_LOAD
    } cell_op_t;

    typedef enum logic [1:0] {
        MOVE_NONE,
        MOVE_RIGHT,
        MOVE_LEFT
    } move_t;

    typedef enum logic [1:0] {
        BR_NONE,
        BR_ZERO,
        BR_NONZERO
    } branch_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2
    } status_t;

    // Decoded instruction class
    typedef struct packed {
        cell_op_t cell_op;
        move_t    move;
        branch_t  branch;
        logic     step_one;  // address advances by one instead of two
        logic     emit;      // put: drive the cell byte
    } class_t;

    // Word carried from front to back
    typedef struct packed {
        class_t                cls;
        logic [OPERAND_W-1:0]  operand;
        logic [READ_W-1:0]     read_value;
    } entry_t;

    // Result word
    typedef struct packed {
        logic [NEXT_W-1:0] next_address;
        logic              byte_valid;
        logic [BYTE_W-1:0] byte_out;
        status_t           status;
    } result_t;

endpackage

// ----- rtl/tape_machine_executor.sv -----
// ----------------------------------------------------------------------------
// tape_machine_executor
// Runs one run-length-compressed tape-machine instruction per input word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel is a queue: drive cmd/operand/read_value and raise push;
//   the word is taken on a clock edge with push high and full low.
//   Result channel is a queue: while empty is low the oldest result sits on
//   next_address/byte_valid/byte_out/status; pop high on an edge takes it.
//   Exactly one result word comes back per input word, in order.
// Timing:
//   Throughput is one word per cycle while the receiver keeps popping.
//   An input word passes the decode queue, tape read issue, the execute
//   stage and the result queue. The cell read-modify-write uses a
//   registered-read tape RAM; a write-back to the same cell by the word just
//   ahead is forwarded, so dependent words run back to back.
// Reset:
//   rst_n clears pointer, instruction address and all queues, then the tape
//   is zeroed by a sweep, one cell per cycle, during which full stays high.
// Stalls:
//   When the receiver stops popping, the two-entry result queue fills, the
//   execute stage holds, then the decode queue fills and full rises. No
//   word is dropped or repeated.
// ----------------------------------------------------------------------------
module tape_machine_executor
    import tme_pkg::*;
#(
    parameter int TAPE_CELLS           = TAPE_CELLS_DEF,
    parameter int CELL_BITS            = CELL_BITS_DEF,
    parameter int PROGRAM_ADDRESS_BITS = PROGRAM_ADDRESS_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // input channel
    input  logic                 push,
    output logic                 full,
    input  logic [CMD_W-1:0]     cmd,
    input  logic [OPERAND_W-1:0] operand,
    input  logic [READ_W-1:0]    read_value,
    // result channel
    output logic                 empty,
    input  logic                 pop,
    output logic [NEXT_W-1:0]    next_address,
    output logic                 byte_valid,
    output logic [BYTE_W-1:0]    byte_out,
    output logic [1:0]           status
);

    logic    front_full;
    logic    clearing;
    logic    issue;
    entry_t  head;
    logic    head_valid;
    result_t res;
    logic    res_push;
    logic    res_full;
    result_t res_head;
    logic [$bits(result_t)-1:0] res_rdata;

    // input is held off during the tape clear sweep
    assign full = front_full || clearing;

    tme_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (push && !full),
        .cmd        (cmd),
        .operand    (operand),
        .read_value (read_value),
        .full       (front_full),
        .pop        (issue),
        .head       (head),
        .head_valid (head_valid)
    );

    tme_back #(
        .TAPE_CELLS           (TAPE_CELLS),
        .CELL_BITS            (CELL_BITS),
        .PROGRAM_ADDRESS_BITS (PROGRAM_ADDRESS_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (issue),
        .clearing   (clearing),
        .res        (res),
        .res_push   (res_push),
        .res_full   (res_full)
    );

    // result queue decouples execution from the receiver
    tme_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_result_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (res_push),
        .wdata (res),
        .full  (res_full),
        .rd    (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign res_head     = result_t'(res_rdata);
    assign next_address = res_head.next_address;
    assign byte_valid   = res_head.byte_valid;
    assign byte_out     = res_head.byte_out;
    assign status       = res_head.status;

endmodule

// ----- rtl/tme_ram.sv -----
// ----------------------------------------------------------------------------
// tme_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/tme_fifo.sv -----
// ----------------------------------------------------------------------------
// tme_fifo
// Small register queue; DEPTH is a power of two.
// ----------------------------------------------------------------------------
module tme_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             rd,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- rtl/tme_front.sv -----
// ----------------------------------------------------------------------------
// tme_front
// Decodes each accepted instruction into its class and queues it for the
// execute side.
// ----------------------------------------------------------------------------
module tme_front
    import tme_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr,
    input  logic [CMD_W-1:0]     cmd,
    input  logic [OPERAND_W-1:0] operand,
    input  logic [READ_W-1:0]    read_value,
    output logic                 full,
    input  logic                 pop,
    output entry_t               head,
    output logic                 head_valid
);

    class_t cls;
    entry_t ent;
    logic   q_empty;
    logic [$bits(entry_t)-1:0] q_rdata;

    always_comb
    begin
        cls.cell_op  = CELL_KEEP;
        cls.move     = MOVE_NONE;
        cls.branch   = BR_NONE;
        cls.step_one = 1'b0;
        cls.emit     = 1'b0;
        unique case (cmd_t'(cmd))
            CMD_ADD:   cls.cell_op = CELL_ADD;
            CMD_SUB:   cls.cell_op = CELL_SUB;
            CMD_GET:
            begin
                cls.cell_op  = CELL_LOAD;
                cls.step_one = 1'b1;
            end
            CMD_PUT:
            begin
                cls.emit     = 1'b1;
                cls.step_one = 1'b1;
            end
            CMD_RIGHT: cls.move   = MOVE_RIGHT;
            CMD_LEFT:  cls.move   = MOVE_LEFT;
            CMD_OPEN:  cls.branch = BR_ZERO;
            CMD_CLOSE: cls.branch = BR_NONZERO;
        endcase
    end

    assign ent.cls        = cls;
    assign ent.operand    = operand;
    assign ent.read_value = read_value;

    tme_fifo #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .wdata (ent),
        .full  (full),
        .rd    (pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    assign head       = entry_t'(q_rdata);
    assign head_valid = !q_empty;

endmodule

// ----- rtl/tme_back.sv -----
// ----------------------------------------------------------------------------
// tme_back
// Execute side: pointer update and tape read on issue, then cell update,
// tape write and address step; forwarding covers back-to-back cell updates.
// ----------------------------------------------------------------------------
module tme_back
    import tme_pkg::*;
#(
    parameter int TAPE_CELLS           = TAPE_CELLS_DEF,
    parameter int CELL_BITS            = CELL_BITS_DEF,
    parameter int PROGRAM_ADDRESS_BITS = PROGRAM_ADDRESS_BITS_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  entry_t  head,
    input  logic    head_valid,
    output logic    pop,
    output logic    clearing,
    output result_t res,
    output logic    res_push,
    input  logic    res_full
);

    localparam int PTR_W = $clog2(TAPE_CELLS);
    localparam int SW    = ((PTR_W > OPERAND_W) ? PTR_W : OPERAND_W) + 1;
    localparam int AW    = PROGRAM_ADDRESS_BITS;

    // tape clear sweep
    logic             clr_reg;
    logic [PTR_W-1:0] clr_cnt_reg;

    // issue side
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    status_t          st_issue;
    logic [SW-1:0]    ptr_ext, opd_ext, sum;

    // execute stage
    logic             s2_valid_reg;
    entry_t           s2_ent_reg;
    logic [PTR_W-1:0] s2_ptr_reg;
    status_t          s2_status_reg;
    logic [AW-1:0]    addr_reg, addr_next;
    logic             fwd_reg;
    logic [CELL_BITS-1:0] fwd_data_reg;

    logic                 s2_fire, s2_load;
    logic [CELL_BITS-1:0] rdata, cur_cell, new_cell, opd_cell;
    logic                 ram_we;
    logic [PTR_W-1:0]     ram_waddr;
    logic [CELL_BITS-1:0] ram_wdata;

    assign clearing = clr_reg;
    assign s2_fire  = s2_valid_reg && !res_full;
    assign s2_load  = !s2_valid_reg || !res_full;
    assign pop      = head_valid && !clr_reg && s2_load;

    // pointer move, decided before the tape read
    assign ptr_ext = SW'(ptr_reg);
    assign opd_ext = SW'(head.operand);
    assign sum     = ptr_ext + opd_ext;

    always_comb
    begin
        ptr_next = ptr_reg;
        st_issue = ST_OK;
        unique case (head.cls.move)
            MOVE_RIGHT:
            begin
                if (sum >= SW'(TAPE_CELLS))
                begin
                    st_issue = ST_OVER;
                end
                else
                begin
                    ptr_next = PTR_W'(sum);
                end
            end
            MOVE_LEFT:
            begin
                if (opd_ext > ptr_ext)
                begin
                    st_issue = ST_UNDER;
                end
                else
                begin
                    ptr_next = PTR_W'(ptr_ext - opd_ext);
                end
            end
            default:
            begin
                ptr_next = ptr_reg;
            end
        endcase
    end

    // cell update
    assign cur_cell = fwd_reg ? fwd_data_reg : rdata;
    assign opd_cell = CELL_BITS'(s2_ent_reg.operand);

    always_comb
    begin
        unique case (s2_ent_reg.cls.cell_op)
            CELL_ADD:  new_cell = cur_cell + opd_cell;
            CELL_SUB:  new_cell = cur_cell - opd_cell;
            CELL_LOAD: new_cell = CELL_BITS'($signed(s2_ent_reg.read_value));
            default:   new_cell = cur_cell;
        endcase
    end

    // address step
    always_comb
    begin
        if (s2_ent_reg.cls.step_one)
        begin
            addr_next = addr_reg + AW'(1);
        end
        else
        begin
            addr_next = addr_reg + AW'(2);
        end
        unique case (s2_ent_reg.cls.branch)
            BR_ZERO:
            begin
                if (cur_cell == '0)
                begin
                    addr_next = AW'(s2_ent_reg.operand) + AW'(2);
                end
            end
            BR_NONZERO:
            begin
                if (cur_cell != '0)
                begin
                    addr_next = AW'(s2_ent_reg.operand) + AW'(2);
                end
            end
            default:
            begin
                addr_next = addr_next;
            end
        endcase
    end

    assign res.next_address = NEXT_W'(addr_next);
    assign res.byte_valid   = s2_ent_reg.cls.emit;
    assign res.byte_out     = s2_ent_reg.cls.emit ? cur_cell[BYTE_W-1:0] : '0;
    assign res.status       = s2_status_reg;
    assign res_push         = s2_fire;

    // tape port: sweep writes zeros, otherwise the executing word writes back
    assign ram_we    = clr_reg || s2_fire;
    assign ram_waddr = clr_reg ? clr_cnt_reg : s2_ptr_reg;
    assign ram_wdata = clr_reg ? '0 : new_cell;

    tme_ram #(
        .WIDTH (CELL_BITS),
        .DEPTH (TAPE_CELLS)
    ) u_tape (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (pop),
        .raddr (ptr_reg),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= 1'b1;
            clr_cnt_reg  <= '0;
            ptr_reg      <= '0;
            addr_reg     <= '0;
            s2_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            if (clr_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + PTR_W'(1);
                if (clr_cnt_reg == PTR_W'(TAPE_CELLS - 1))
                begin
                    clr_reg <= 1'b0;
                end
            end
            if (s2_fire)
            begin
                addr_reg <= addr_next;
            end
            if (pop)
            begin
                ptr_reg <= ptr_next;
                fwd_reg <= s2_fire && (s2_ptr_reg == ptr_reg);
            end
            if (s2_load)
            begin
                s2_valid_reg <= pop;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s2_ent_reg    <= head;
            s2_ptr_reg    <= ptr_reg;
            s2_status_reg <= st_issue;
            fwd_data_reg  <= new_cell;
        end
    end

endmodule
